// ----- hw/rtl/rtc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_pkg: shared types and helpers of the rectangle clip unit
// Payload structs, configuration record, register indexes and saturation.
// ----------------------------------------------------------------------------
package rtc_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int IDX_W         = 4;
	localparam int QUEUE_DEPTH   = 4;

	typedef enum logic [IDX_W-1:0] {
		REG_ORIGIN_X    = 4'd0,
		REG_ORIGIN_Y    = 4'd1,
		REG_SCALE_X     = 4'd2,
		REG_SCALE_Y     = 4'd3,
		REG_CLIP_LEFT   = 4'd4,
		REG_CLIP_TOP    = 4'd5,
		REG_CLIP_RIGHT  = 4'd6,
		REG_CLIP_BOTTOM = 4'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] left_in;
		logic signed [31:0] top_in;
		logic signed [31:0] right_in;
		logic signed [31:0] bottom_in;
		logic signed [31:0] tex_s_start_in;
		logic signed [31:0] tex_t_start_in;
		logic signed [31:0] tex_s_end_in;
		logic signed [31:0] tex_t_end_in;
	} in_t;

	typedef struct packed {
		logic signed [31:0] left_out;
		logic signed [31:0] top_out;
		logic signed [31:0] right_out;
		logic signed [31:0] bottom_out;
		logic signed [31:0] tex_s_start_out;
		logic signed [31:0] tex_t_start_out;
		logic signed [31:0] tex_s_end_out;
		logic signed [31:0] tex_t_end_out;
		logic               visible;
	} out_t;

	typedef struct packed {
		logic signed [31:0] c1;
		logic signed [31:0] c2;
		logic signed [31:0] u1;
		logic signed [31:0] u2;
	} lane_t;

	typedef struct packed {
		lane_t x;
		lane_t y;
	} item_t;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic        [30:0] scale_x;
		logic        [30:0] scale_y;
		logic signed [31:0] clip_left;
		logic signed [31:0] clip_top;
		logic signed [31:0] clip_right;
		logic signed [31:0] clip_bottom;
	} cfg_t;

	function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
		logic signed [31:0] r;
		if (v > 65'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -65'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// ----- hw/rtl/rtc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_front: corner transform front end
// Scales and offsets the corners into screen space in two stages.
// ----------------------------------------------------------------------------
module rtc_front #(
	parameter int FRAC_BITS = rtc_pkg::FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  rtc_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_ready,
	input  rtc_pkg::in_t  in_data,
	output logic          push_valid,
	input  logic          push_ready,
	output rtc_pkg::item_t push_item
);
	import rtc_pkg::*;

	logic signed [63:0] prod_s1 [4];
	logic signed [31:0] tex_s1 [4];
	logic               valid_s1;
	item_t              item_s2;
	logic               valid_s2;
	logic               adv;

	function automatic logic signed [31:0] xform(input logic signed [63:0] prod,
		input logic signed [31:0] org);
		logic signed [63:0] p;
		logic signed [31:0] p32;
		logic signed [32:0] sum;
		p   = prod >>> FRAC_BITS;
		p32 = sat32({p[63], p});
		sum = {p32[31], p32} + {org[31], org};
		return sat32({{32{sum[32]}}, sum});
	endfunction

	assign adv        = !valid_s2 || push_ready;
	assign in_ready   = adv;
	assign push_valid = valid_s2;
	assign push_item  = item_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1[0] <= in_data.left_in   * $signed({1'b0, cfg.scale_x});
			prod_s1[1] <= in_data.top_in    * $signed({1'b0, cfg.scale_y});
			prod_s1[2] <= in_data.right_in  * $signed({1'b0, cfg.scale_x});
			prod_s1[3] <= in_data.bottom_in * $signed({1'b0, cfg.scale_y});
			tex_s1[0]  <= in_data.tex_s_start_in;
			tex_s1[1]  <= in_data.tex_t_start_in;
			tex_s1[2]  <= in_data.tex_s_end_in;
			tex_s1[3]  <= in_data.tex_t_end_in;
			item_s2.x.c1 <= xform(prod_s1[0], cfg.origin_x);
			item_s2.y.c1 <= xform(prod_s1[1], cfg.origin_y);
			item_s2.x.c2 <= xform(prod_s1[2], cfg.origin_x);
			item_s2.y.c2 <= xform(prod_s1[3], cfg.origin_y);
			item_s2.x.u1 <= tex_s1[0];
			item_s2.y.u1 <= tex_s1[1];
			item_s2.x.u2 <= tex_s1[2];
			item_s2.y.u2 <= tex_s1[3];
		end
	end

endmodule

// ----- hw/rtl/rtc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_queue: short item queue
// Decouples the transform front end from the clip back end.
// ----------------------------------------------------------------------------
module rtc_queue #(
	parameter int DEPTH = rtc_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  rtc_pkg::item_t push_item,
	output logic           pop_valid,
	input  logic           pop_ready,
	output rtc_pkg::item_t pop_item,
	output logic           full
);
	import rtc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t         mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          push;
	logic          pop;

	assign full       = (cnt_q == CW'(DEPTH));
	assign push_ready = !full;
	assign pop_valid  = (cnt_q != '0);
	assign pop_item   = mem_q[rd_q];
	assign push       = push_valid && !full;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

endmodule

// ----- hw/rtl/rtc_clip.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_clip: one clip edge with texture re-interpolation
// Bit-per-stage floor divider, ratio multiply and saturating update.
// ----------------------------------------------------------------------------
module rtc_clip #(
	parameter int   FRAC_BITS = rtc_pkg::FRAC_BITS_DEF,
	parameter logic LOW_EDGE  = 1'b1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic signed [31:0] bound,
	input  logic               in_valid,
	input  rtc_pkg::lane_t     in_lane,
	output logic               out_valid,
	output rtc_pkg::lane_t     out_lane
);
	import rtc_pkg::*;

	localparam int NW = 33 + FRAC_BITS;
	localparam logic [NW:0] LIM_NEG = (NW+1)'(1) << 31;

	typedef struct packed {
		lane_t              lane;
		logic               cond;
		logic               dnz;
		logic               neg;
		logic signed [31:0] diff;
	} ctx_t;

	logic [32:0]   rem_sd  [NW+1];
	logic [NW-1:0] nq_sd   [NW+1];
	logic [32:0]   dabs_sd [NW+1];
	ctx_t          ctx_sd  [NW+1];
	logic          vld_sd  [NW+1];

	logic signed [31:0] csel;
	logic signed [32:0] num;
	logic signed [32:0] den;
	logic signed [32:0] dif;
	logic [32:0]        nabs;
	logic [32:0]        dabs;
	ctx_t               ctx_in;

	logic [NW-1:0]      q_f;
	logic [NW:0]        mag;
	logic signed [31:0] ratio;

	ctx_t               ctx_s1, ctx_s2;
	logic signed [31:0] ratio_s1;
	logic signed [63:0] prod_s2;
	logic               vld_s1, vld_s2, vld_s3;
	lane_t              lane_s3;

	logic signed [63:0] delta;
	logic signed [64:0] sum;
	logic signed [31:0] tex;
	logic signed [31:0] ntex;
	lane_t              lane_nx;

	always_comb begin
		csel = LOW_EDGE ? in_lane.c1 : in_lane.c2;
		num  = {csel[31], csel} - {bound[31], bound};
		den  = {in_lane.c1[31], in_lane.c1} - {in_lane.c2[31], in_lane.c2};
		dif  = {in_lane.u2[31], in_lane.u2} - {in_lane.u1[31], in_lane.u1};
		nabs = num[32] ? (~num + 33'd1) : num;
		dabs = den[32] ? (~den + 33'd1) : den;
		ctx_in.lane = in_lane;
		ctx_in.cond = LOW_EDGE ? (in_lane.c1 < bound) : (in_lane.c2 > bound);
		ctx_in.dnz  = (den != '0);
		ctx_in.neg  = num[32] ^ den[32];
		ctx_in.diff = sat32({{32{dif[32]}}, dif});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_sd[0] <= 1'b0;
		else if (en)
			vld_sd[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_sd[0]  <= '0;
			nq_sd[0]   <= NW'(nabs) << FRAC_BITS;
			dabs_sd[0] <= dabs;
			ctx_sd[0]  <= ctx_in;
		end
	end

	for (genvar k = 0; k < NW; k++) begin : g_div
		logic [33:0] t;
		logic        ge;
		logic [33:0] t_sub;
		assign t     = {rem_sd[k], nq_sd[k][NW-1]};
		assign ge    = (t >= {1'b0, dabs_sd[k]});
		assign t_sub = t - {1'b0, dabs_sd[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_sd[k+1] <= 1'b0;
			else if (en)
				vld_sd[k+1] <= vld_sd[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sd[k+1]  <= ge ? t_sub[32:0] : t[32:0];
				nq_sd[k+1]   <= {nq_sd[k][NW-2:0], ge};
				dabs_sd[k+1] <= dabs_sd[k];
				ctx_sd[k+1]  <= ctx_sd[k];
			end
		end
	end

	always_comb begin
		q_f = nq_sd[NW];
		mag = {1'b0, q_f} + (NW+1)'(rem_sd[NW] != '0);
		if (!ctx_sd[NW].neg)
			ratio = ((q_f >> 31) != '0) ? 32'sh7fffffff : q_f[31:0];
		else
			ratio = (mag > LIM_NEG) ? 32'sh80000000 : -(mag[31:0]);
	end

	always_comb begin
		delta   = prod_s2 >>> FRAC_BITS;
		tex     = LOW_EDGE ? ctx_s2.lane.u1 : ctx_s2.lane.u2;
		sum     = {{33{tex[31]}}, tex} + {delta[63], delta};
		ntex    = (ctx_s2.cond && ctx_s2.dnz) ? sat32(sum) : tex;
		lane_nx = ctx_s2.lane;
		if (LOW_EDGE) begin
			lane_nx.u1 = ntex;
			if (ctx_s2.cond)
				lane_nx.c1 = bound;
		end else begin
			lane_nx.u2 = ntex;
			if (ctx_s2.cond)
				lane_nx.c2 = bound;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_sd[NW];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ratio_s1 <= ratio;
			ctx_s1   <= ctx_sd[NW];
			prod_s2  <= ratio_s1 * ctx_s1.diff;
			ctx_s2   <= ctx_s1;
			lane_s3  <= lane_nx;
		end
	end

	assign out_valid = vld_s3;
	assign out_lane  = lane_s3;

endmodule

// ----- hw/rtl/rtc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_back: clip back end
// Left then right on x, top then bottom on y, and the output register.
// ----------------------------------------------------------------------------
module rtc_back #(
	parameter int FRAC_BITS = rtc_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rtc_pkg::cfg_t  cfg,
	input  logic           in_valid,
	output logic           in_ready,
	input  rtc_pkg::item_t in_item,
	output logic           out_valid,
	input  logic           out_ready,
	output rtc_pkg::out_t  out_data
);
	import rtc_pkg::*;

	logic  en;
	logic  vx1, vx2, vy1, vy2;
	lane_t lx1, lx2, ly1, ly2;
	logic  out_valid_q;
	out_t  out_q;

	assign en       = !out_valid_q || out_ready;
	assign in_ready = en;

	rtc_clip #(.FRAC_BITS(FRAC_BITS), .LOW_EDGE(1'b1)) u_left (
		.clk(clk), .arst_n(arst_n), .en(en), .bound(cfg.clip_left),
		.in_valid(in_valid), .in_lane(in_item.x), .out_valid(vx1), .out_lane(lx1)
	);
	rtc_clip #(.FRAC_BITS(FRAC_BITS), .LOW_EDGE(1'b0)) u_right (
		.clk(clk), .arst_n(arst_n), .en(en), .bound(cfg.clip_right),
		.in_valid(vx1), .in_lane(lx1), .out_valid(vx2), .out_lane(lx2)
	);
	rtc_clip #(.FRAC_BITS(FRAC_BITS), .LOW_EDGE(1'b1)) u_top (
		.clk(clk), .arst_n(arst_n), .en(en), .bound(cfg.clip_top),
		.in_valid(in_valid), .in_lane(in_item.y), .out_valid(vy1), .out_lane(ly1)
	);
	rtc_clip #(.FRAC_BITS(FRAC_BITS), .LOW_EDGE(1'b0)) u_bottom (
		.clk(clk), .arst_n(arst_n), .en(en), .bound(cfg.clip_bottom),
		.in_valid(vy1), .in_lane(ly1), .out_valid(vy2), .out_lane(ly2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (en)
			out_valid_q <= vx2 && vy2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.left_out        <= lx2.c1;
			out_q.top_out         <= ly2.c1;
			out_q.right_out       <= lx2.c2;
			out_q.bottom_out      <= ly2.c2;
			out_q.tex_s_start_out <= lx2.u1;
			out_q.tex_t_start_out <= ly2.u1;
			out_q.tex_s_end_out   <= lx2.u2;
			out_q.tex_t_end_out   <= ly2.u2;
			out_q.visible         <= (lx2.c1 < lx2.c2) && (ly2.c1 < ly2.c2);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- hw/rtl/rect_transform_clip_texcoord.sv -----
`timescale 1ns / 1ps
// Throughput: one item per cycle unless out_ready stalls the back end; each
// clip edge runs a one-bit-per-stage floor divider of FRAC_BITS + 33 stages,
// four of them, two in series per axis.
// Reset clears all valid state and the queue and returns the registers to
// origin 0, scale 1.0 at unsigned Q15.16, bounds 0 and 0x7FFFFFFF.
// ----------------------------------------------------------------------------
// rect_transform_clip_texcoord: rectangle transform and clip unit
// Front transform, item queue and pipelined clip back end with config regs.
// ----------------------------------------------------------------------------
module rect_transform_clip_texcoord #(
	parameter int FRAC_BITS = rtc_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [rtc_pkg::IDX_W-1:0] cfg_index,
	input  logic [31:0]               cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  rtc_pkg::in_t              in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output rtc_pkg::out_t             out_data
);
	import rtc_pkg::*;

	cfg_t  cfg_q;
	logic  f_valid, f_ready;
	item_t f_item;
	logic  q_valid, q_ready, q_full;
	item_t q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x    <= '0;
			cfg_q.origin_y    <= '0;
			cfg_q.scale_x     <= 31'd65536;
			cfg_q.scale_y     <= 31'd65536;
			cfg_q.clip_left   <= '0;
			cfg_q.clip_top    <= '0;
			cfg_q.clip_right  <= 32'sh7fffffff;
			cfg_q.clip_bottom <= 32'sh7fffffff;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ORIGIN_X:    cfg_q.origin_x    <= cfg_wdata;
				REG_ORIGIN_Y:    cfg_q.origin_y    <= cfg_wdata;
				REG_SCALE_X:     cfg_q.scale_x     <= cfg_wdata[30:0];
				REG_SCALE_Y:     cfg_q.scale_y     <= cfg_wdata[30:0];
				REG_CLIP_LEFT:   cfg_q.clip_left   <= cfg_wdata;
				REG_CLIP_TOP:    cfg_q.clip_top    <= cfg_wdata;
				REG_CLIP_RIGHT:  cfg_q.clip_right  <= cfg_wdata;
				REG_CLIP_BOTTOM: cfg_q.clip_bottom <= cfg_wdata;
				default: ;
			endcase
		end
	end

	rtc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.push_valid(f_valid), .push_ready(f_ready), .push_item(f_item)
	);

	rtc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_valid(f_valid), .push_ready(f_ready), .push_item(f_item),
		.pop_valid(q_valid), .pop_ready(q_ready), .pop_item(q_item),
		.full(q_full)
	);

	rtc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> q_full)
		else $error("front stalled while queue had room");

	a_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("pending result dropped");

	a_visible_x: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.visible |->
			(out_data.left_out < out_data.right_out) &&
			(out_data.top_out < out_data.bottom_out))
		else $error("visible set on empty rectangle");

endmodule

// ----- verif/tb_rect_transform_clip_texcoord.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rect_transform_clip_texcoord: testbench of the rectangle clip unit
// Drives rectangles through the valid/ready ports under random gaps and stalls
// and checks every result against a behavioral clip predictor or fixed value.
// Several register settings are used, written only while the unit is idle.
// ----------------------------------------------------------------------------
module tb_rect_transform_clip_texcoord;
	import rtc_pkg::*;

	localparam int FRAC      = 16;
	localparam int LATENCY   = 2 * FRAC + 78;
	localparam int WD_LIMIT  = 4000;
	localparam int N_RANDOM  = 1100;

	typedef struct {
		longint ox, oy, sx, sy, cl, ct, cr, cb;
	} clip_cfg_t;

	typedef struct packed {
		in_t  stim;
		logic check_fixed;
		out_t fixed;
	} dir_row_t;

	logic   clk;
	logic   arst_n;
	logic   cfg_we;
	logic   [IDX_W-1:0] cfg_index;
	logic   [31:0] cfg_wdata;
	logic   in_valid;
	logic   in_ready;
	in_t    in_data;
	logic   out_valid;
	logic   out_ready;
	out_t   out_data;

	clip_cfg_t cfg;
	out_t   expected_rects[$];
	out_t   fixed_rects[$];
	bit     fixed_flags[$];
	int     errors;
	int     idle_cycles;
	bit     long_hold;

	rect_transform_clip_texcoord i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic longint sat(longint v);
		longint r;
		r = v;
		if (v > 64'sd2147483647)
			r = 64'sd2147483647;
		else if (v < -64'sd2147483648)
			r = -64'sd2147483648;
		return r;
	endfunction

	function automatic longint floor_div(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && ((a < 0) != (b < 0)))
			q = q - 1;
		return q;
	endfunction

	function automatic longint to_screen(longint c, longint s, longint o);
		return sat(sat(floor_div(c * s, 64'sd1 <<< FRAC)) + o);
	endfunction

	function automatic longint shift_tex(longint tex, longint num, longint den,
			longint u1, longint u2);
		longint ratio;
		longint span;
		if (den == 0)
			return tex;
		ratio = sat(floor_div(num * (64'sd1 <<< FRAC), den));
		span = sat(u2 - u1);
		return sat(tex + floor_div(ratio * span, 64'sd1 <<< FRAC));
	endfunction

	function automatic out_t clip_rect(in_t r);
		longint x1, y1, x2, y2, s1, t1, s2, t2;
		out_t o;
		x1 = to_screen(longint'(r.left_in), cfg.sx, cfg.ox);
		y1 = to_screen(longint'(r.top_in), cfg.sy, cfg.oy);
		x2 = to_screen(longint'(r.right_in), cfg.sx, cfg.ox);
		y2 = to_screen(longint'(r.bottom_in), cfg.sy, cfg.oy);
		s1 = r.tex_s_start_in;
		t1 = r.tex_t_start_in;
		s2 = r.tex_s_end_in;
		t2 = r.tex_t_end_in;
		if (x1 < cfg.cl) begin
			s1 = shift_tex(s1, x1 - cfg.cl, x1 - x2, s1, s2);
			x1 = cfg.cl;
		end
		if (x2 > cfg.cr) begin
			s2 = shift_tex(s2, x2 - cfg.cr, x1 - x2, s1, s2);
			x2 = cfg.cr;
		end
		if (y1 < cfg.ct) begin
			t1 = shift_tex(t1, y1 - cfg.ct, y1 - y2, t1, t2);
			y1 = cfg.ct;
		end
		if (y2 > cfg.cb) begin
			t2 = shift_tex(t2, y2 - cfg.cb, y1 - y2, t1, t2);
			y2 = cfg.cb;
		end
		o.left_out        = x1[31:0];
		o.top_out         = y1[31:0];
		o.right_out       = x2[31:0];
		o.bottom_out      = y2[31:0];
		o.tex_s_start_out = s1[31:0];
		o.tex_t_start_out = t1[31:0];
		o.tex_s_end_out   = s2[31:0];
		o.tex_t_end_out   = t2[31:0];
		o.visible         = (x1 < x2) && (y1 < y2);
		return o;
	endfunction

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_ORIGIN_X:    cfg.ox = longint'($signed(value));
			REG_ORIGIN_Y:    cfg.oy = longint'($signed(value));
			REG_SCALE_X:     cfg.sx = longint'({33'd0, value[30:0]});
			REG_SCALE_Y:     cfg.sy = longint'({33'd0, value[30:0]});
			REG_CLIP_LEFT:   cfg.cl = longint'($signed(value));
			REG_CLIP_TOP:    cfg.ct = longint'($signed(value));
			REG_CLIP_RIGHT:  cfg.cr = longint'($signed(value));
			REG_CLIP_BOTTOM: cfg.cb = longint'($signed(value));
			default: ;
		endcase
	endtask

	task automatic load_setting(logic [31:0] ox, logic [31:0] oy, logic [31:0] sx,
			logic [31:0] sy, logic [31:0] cl, logic [31:0] ct, logic [31:0] cr,
			logic [31:0] cb);
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_SCALE_X, sx);
		write_reg(REG_SCALE_Y, sy);
		write_reg(REG_CLIP_LEFT, cl);
		write_reg(REG_CLIP_TOP, ct);
		write_reg(REG_CLIP_RIGHT, cr);
		write_reg(REG_CLIP_BOTTOM, cb);
	endtask

	task automatic send_rect(in_t r, bit has_fixed, out_t fixed);
		int gap;
		gap = $urandom_range(0, 16);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		expected_rects.push_back(clip_rect(r));
		fixed_flags.push_back(has_fixed);
		fixed_rects.push_back(fixed);
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_rects.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		logic [31:0] v;
		case ($urandom_range(0, 5))
			0: v = $urandom;
			1: v = {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
			2: v = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: v = $signed(32'($urandom_range(0, 2000))) - 1000 <<< FRAC;
		endcase
		return v;
	endfunction

	function automatic in_t rand_rect();
		in_t r;
		logic [31:0] w, h;
		r.left_in = rand_coord();
		r.top_in  = rand_coord();
		w = ($urandom_range(0, 1200) <<< FRAC) - 5;
		h = ($urandom_range(0, 1200) <<< FRAC) - 5;
		if ($urandom_range(0, 4) != 0) begin
			r.right_in  = r.left_in + $signed(w);
			r.bottom_in = r.top_in + $signed(h);
		end else begin
			r.right_in  = rand_coord();
			r.bottom_in = rand_coord();
		end
		if ($urandom_range(0, 7) == 0)
			r.right_in = r.left_in;
		r.tex_s_start_in = $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 65536);
		r.tex_t_start_in = $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 65536);
		r.tex_s_end_in   = $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 65536);
		r.tex_t_end_in   = $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 65536);
		return r;
	endfunction

	// directed rows: reset settings, unit scale, origin 0, bounds 0..max
	function automatic dir_row_t row(int l, int t, int rr, int b, int s1, int t1,
			int s2, int t2, bit chk, out_t o);
		dir_row_t d;
		d.stim = '{l, t, rr, b, s1, t1, s2, t2};
		d.check_fixed = chk;
		d.fixed = o;
		return d;
	endfunction

	initial begin
		dir_row_t dir_rows[$];
		out_t none;
		in_t r;
		int n;
		errors = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		in_data = '0;
		cfg = '{0, 0, 65536, 65536, 0, 0, 64'sd2147483647, 64'sd2147483647};
		none = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		dir_rows.push_back(row(10 << 16, 20 << 16, 30 << 16, 40 << 16, 1, 2, 3, 4, 1,
			'{10 << 16, 20 << 16, 30 << 16, 40 << 16, 1, 2, 3, 4, 1'b1}));
		dir_rows.push_back(row(0, 0, 0, 0, 5, 6, 7, 8, 1,
			'{0, 0, 0, 0, 5, 6, 7, 8, 1'b0}));
		dir_rows.push_back(row(-100 << 16, 0, 100 << 16, 50 << 16, 0, 0, 65536, 65536, 1,
			'{0, 0, 100 << 16, 50 << 16, 32768, 0, 65536, 65536, 1'b1}));
		dir_rows.push_back(row(-5 << 16, -5 << 16, -5 << 16, -5 << 16, 9, 9, 1, 1, 1,
			'{0, 0, -5 << 16, -5 << 16, 9, 9, 1, 1, 1'b0}));
		dir_rows.push_back(row(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 0, none));
		dir_rows.push_back(row(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
			32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0, none));
		dir_rows.push_back(row(50 << 16, 50 << 16, 10 << 16, 10 << 16, 0, 0, 1, 1, 0, none));
		dir_rows.push_back(row(-1, -1, 1, 1, 32'hffffffff, 0, 0, 32'hffffffff, 0, none));
		foreach (dir_rows[i])
			send_rect(dir_rows[i].stim, dir_rows[i].check_fixed, dir_rows[i].fixed);
		drain();

		load_setting(32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
			32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
		for (int i = 0; i < 6; i++) begin
			send_rect(dir_rows[i].stim, 0, none);
		end
		drain();
		load_setting(32'h7fffffff, 32'h80000000, 0, 0,
			32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
		for (int i = 0; i < 6; i++)
			send_rect(dir_rows[i].stim, 0, none);
		drain();

		for (int phase = 0; phase < 4; phase++) begin
			load_setting(($urandom_range(0, 400) - 200) <<< FRAC,
				($urandom_range(0, 400) - 200) <<< FRAC,
				phase == 3 ? $urandom : $urandom_range(16384, 262144),
				phase == 3 ? $urandom : $urandom_range(16384, 262144),
				($urandom_range(0, 400) - 300) <<< FRAC,
				($urandom_range(0, 400) - 300) <<< FRAC,
				phase == 2 ? $urandom : ($urandom_range(0, 800) - 200) <<< FRAC,
				phase == 2 ? $urandom : ($urandom_range(0, 800) - 200) <<< FRAC);
			n = N_RANDOM / 4;
			for (int i = 0; i < n; i++) begin
				if (phase == 1 && i == 20)
					long_hold = 1;
				r = rand_rect();
				send_rect(r, 0, none);
			end
			drain();
		end
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		int stall;
		int hold;
		out_ready = 1'b0;
		long_hold = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				long_hold = 0;
				out_ready <= 1'b0;
				hold = 0;
				while (hold < 400) begin
					@(negedge clk);
					hold++;
				end
			end
			stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		out_t exp_r;
		bit has_fixed;
		out_t fixed;
		if (arst_n && out_valid && out_ready) begin
			if (expected_rects.size() == 0) begin
				$error("result with no rectangle outstanding");
				errors++;
			end else begin
				exp_r = expected_rects.pop_front();
				has_fixed = fixed_flags.pop_front();
				fixed = fixed_rects.pop_front();
				if (has_fixed)
					exp_r = fixed;
				if (out_data.left_out !== exp_r.left_out) begin
					$error("left_out exp %0d got %0d", exp_r.left_out, out_data.left_out);
					errors++;
				end
				if (out_data.top_out !== exp_r.top_out) begin
					$error("top_out exp %0d got %0d", exp_r.top_out, out_data.top_out);
					errors++;
				end
				if (out_data.right_out !== exp_r.right_out) begin
					$error("right_out exp %0d got %0d", exp_r.right_out, out_data.right_out);
					errors++;
				end
				if (out_data.bottom_out !== exp_r.bottom_out) begin
					$error("bottom_out exp %0d got %0d", exp_r.bottom_out,
						out_data.bottom_out);
					errors++;
				end
				if (out_data.tex_s_start_out !== exp_r.tex_s_start_out) begin
					$error("tex_s_start_out exp %0d got %0d", exp_r.tex_s_start_out,
						out_data.tex_s_start_out);
					errors++;
				end
				if (out_data.tex_t_start_out !== exp_r.tex_t_start_out) begin
					$error("tex_t_start_out exp %0d got %0d", exp_r.tex_t_start_out,
						out_data.tex_t_start_out);
					errors++;
				end
				if (out_data.tex_s_end_out !== exp_r.tex_s_end_out) begin
					$error("tex_s_end_out exp %0d got %0d", exp_r.tex_s_end_out,
						out_data.tex_s_end_out);
					errors++;
				end
				if (out_data.tex_t_end_out !== exp_r.tex_t_end_out) begin
					$error("tex_t_end_out exp %0d got %0d", exp_r.tex_t_end_out,
						out_data.tex_t_end_out);
					errors++;
				end
				if (out_data.visible !== exp_r.visible) begin
					$error("visible exp %0d got %0d", exp_r.visible, out_data.visible);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we
				|| expected_rects.size() == 0)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WD_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule

// ----- files.f -----
hw/rtl/rtc_pkg.sv
hw/rtl/rtc_front.sv
hw/rtl/rtc_queue.sv
hw/rtl/rtc_clip.sv
hw/rtl/rtc_back.sv
hw/rtl/rect_transform_clip_texcoord.sv
verif/tb_rect_transform_clip_texcoord.sv
